/* src/dafeed_pkg.sv */
// ---------------------------------------------------------------------------
// dafeed_pkg
// shared types and constants for the dac audio frame feeder
// ---------------------------------------------------------------------------
package dafeed_pkg;

  localparam int PCM_W       = 16;
  localparam int CODE_W      = 12;
  localparam int FL_W        = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QDEPTH      = 4;
  localparam int FIFO_FRAMES = 8;
  localparam int RESET_FRAME_LEN = 120;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_FRAME_DEF   = 128;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = CFG_IDX_W'(1);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // one tick result travelling from the front to the back
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              rd;
    logic              silence;
    logic              start;
  } res_t;

endpackage

/* src/dac_audio_frame_feeder.sv */
// ---------------------------------------------------------------------------
// dac_audio_frame_feeder
// frame based pcm to dac code feeder with underrun silence
// ---------------------------------------------------------------------------
// Takes one input word per clock while the queue has room: a push stores a
// 16-bit PCM sample as a 12-bit offset code in a sample fifo of 8 frames
// (pushes into a full fifo are dropped), a tick yields one DAC word on the
// output. A tick's word passes through the read stage of the sample memory,
// which has one write port and one read port, the short queue and the output
// register before it appears on out_valid; the queue keeps input at one word
// per clock while the output is stalled until the queue fills. The sample
// memory has no clearing pass after reset. Configuration writes are taken
// every clock and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module dac_audio_frame_feeder
  import dafeed_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_FRAME   = MAX_FRAME_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic signed [PCM_W-1:0] in_pcm_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CODE_W-1:0]       out_dac_word,
  output logic                    out_is_silence,
  output logic                    out_frame_start,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic                        q_push, q_pop, q_valid;
  res_t                        q_in, q_out;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  assign cfg_ready = 1'b1;

  dafeed_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_FRAME   (MAX_FRAME)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_pcm_sample (in_pcm_sample),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  dafeed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .count     (q_count)
  );

  dafeed_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dac_word    (out_dac_word),
    .out_is_silence  (out_is_silence),
    .out_frame_start (out_frame_start)
  );

endmodule

/* src/dafeed_front.sv */
// ---------------------------------------------------------------------------
// dafeed_front
// accepts pushes and ticks, keeps the sample fifo and frame state
// ---------------------------------------------------------------------------
module dafeed_front
  import dafeed_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_FRAME   = MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic signed [PCM_W-1:0]       in_pcm_sample,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
  output logic                          q_push,
  output res_t                          q_data
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam int POS_W = $clog2(MAX_FRAME);
  localparam int QC_W  = $clog2(QDEPTH + 1);
  localparam int RST_LEN = (RESET_FRAME_LEN > MAX_FRAME) ? MAX_FRAME : RESET_FRAME_LEN;
  localparam int RST_CAP = (RST_LEN * FIFO_FRAMES > STORE_DEPTH) ? STORE_DEPTH
                                                                 : RST_LEN * FIFO_FRAMES;

  logic [CODE_W-1:0] mem [STORE_DEPTH];

  logic              enable_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  cap_r;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              silence_r, silence_nxt;
  logic              s1_valid_r;
  logic              s1_rd_r, s1_sil_r, s1_start_r;
  logic [CODE_W-1:0] rdata_r;

  logic [LEN_W-1:0]  new_len;
  logic [CNT_W-1:0]  new_cap;
  logic              acc, do_push, do_tick, do_rd, tick_start, tick_sil;
  logic [CODE_W-1:0] code;

  // room for the word in stage one plus one more
  always_comb begin
    if (s1_valid_r) begin
      in_ready = (q_count <= QC_W'(QDEPTH - 2));
    end else begin
      in_ready = (q_count <= QC_W'(QDEPTH - 1));
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      new_len = LEN_W'(1);
    end else if (32'(cfg_data) > MAX_FRAME) begin
      new_len = LEN_W'(MAX_FRAME);
    end else begin
      new_len = LEN_W'(cfg_data);
    end
    if (32'(new_len) * FIFO_FRAMES > STORE_DEPTH) begin
      new_cap = CNT_W'(STORE_DEPTH);
    end else begin
      new_cap = CNT_W'(32'(new_len) * FIFO_FRAMES);
    end
  end

  assign acc        = in_valid && in_ready && enable_r;
  assign do_push    = acc && (in_kind == KIND_PUSH) && (fill_r < cap_r);
  assign do_tick    = acc && (in_kind == KIND_TICK);
  assign tick_start = (pos_r == '0);
  assign tick_sil   = tick_start ? (32'(fill_r) < 32'(len_r)) : silence_r;
  assign do_rd      = do_tick && !tick_sil && (fill_r != '0);
  assign code       = {~in_pcm_sample[PCM_W-1], in_pcm_sample[PCM_W-2:PCM_W-CODE_W]};

  always_comb begin
    wptr_nxt    = wptr_r;
    rptr_nxt    = rptr_r;
    fill_nxt    = fill_r;
    pos_nxt     = pos_r;
    silence_nxt = silence_r;
    if (do_push) begin
      wptr_nxt = (32'(wptr_r) == STORE_DEPTH - 1) ? '0 : wptr_r + PTR_W'(1);
      fill_nxt = fill_r + CNT_W'(1);
    end
    if (do_tick) begin
      silence_nxt = tick_sil;
      pos_nxt     = (32'(pos_r) + 1 >= 32'(len_r)) ? '0 : pos_r + POS_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (32'(rptr_r) == STORE_DEPTH - 1) ? '0 : rptr_r + PTR_W'(1);
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      len_r      <= LEN_W'(RST_LEN);
      cap_r      <= CNT_W'(RST_CAP);
      wptr_r     <= '0;
      rptr_r     <= '0;
      fill_r     <= '0;
      pos_r      <= '0;
      silence_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_ENABLE) begin
        enable_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_FRAME_LEN) begin
        len_r <= new_len;
        cap_r <= new_cap;
      end
      wptr_r     <= wptr_nxt;
      rptr_r     <= rptr_nxt;
      fill_r     <= fill_nxt;
      pos_r      <= pos_nxt;
      silence_r  <= silence_nxt;
      s1_valid_r <= do_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= code;
    end
    if (do_rd) begin
      rdata_r <= mem[rptr_r];
    end
    s1_rd_r    <= do_rd;
    s1_sil_r   <= tick_sil;
    s1_start_r <= tick_start;
  end

  assign q_push          = s1_valid_r;
  assign q_data.code     = rdata_r;
  assign q_data.rd       = s1_rd_r;
  assign q_data.silence  = s1_sil_r;
  assign q_data.start    = s1_start_r;

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= STORE_DEPTH)
    else $error("fill count above store depth");

  a_sil_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_sil_r |-> !s1_rd_r)
    else $error("read during silence frame");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !cfg_we |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("push did not raise fill count");

  a_tick_word: assert property (@(posedge clk) disable iff (!rst_n)
    do_tick |=> s1_valid_r && s1_start_r == $past(pos_r == '0))
    else $error("tick lost or wrong frame start");

endmodule

/* src/dafeed_queue.sv */
// ---------------------------------------------------------------------------
// dafeed_queue
// short word queue between the front and the back
// ---------------------------------------------------------------------------
module dafeed_queue
  import dafeed_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  res_t                        push_data,
  input  logic                        pop,
  output logic                        q_valid,
  output res_t                        q_data,
  output logic [$clog2(QDEPTH+1)-1:0] count
);

  localparam int QP_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  res_t             buf_r [QDEPTH];
  logic [QP_W-1:0]  wr_r, rd_r;
  logic [QC_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (32'(wr_r) == QDEPTH - 1) ? '0 : wr_r + QP_W'(1);
      end
      if (pop) begin
        rd_r <= (32'(rd_r) == QDEPTH - 1) ? '0 : rd_r + QP_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QC_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= push_data;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_data  = buf_r[rd_r];
  assign count   = count_r;

endmodule

/* src/dafeed_back.sv */
// ---------------------------------------------------------------------------
// dafeed_back
// forms the dac word and holds it in the output register
// ---------------------------------------------------------------------------
module dafeed_back
  import dafeed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  res_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_dac_word,
  output logic              out_is_silence,
  output logic              out_frame_start
);

  logic              valid_r;
  logic [CODE_W-1:0] word_r;
  logic              sil_r, start_r;

  assign q_pop = q_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_valid;
    end
  end

  // dry data frame or silence gives code zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r  <= q_data.rd ? q_data.code : '0;
      sil_r   <= q_data.silence;
      start_r <= q_data.start;
    end
  end

  assign out_valid       = valid_r;
  assign out_dac_word    = word_r;
  assign out_is_silence  = sil_r;
  assign out_frame_start = start_r;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the dac audio frame feeder
// ---------------------------------------------------------------------------
// A queue of pending words feeds a clocked driver, a clocked monitor predicts
// every tick's dac word from its own copy of the sample fifo and frame state,
// and compares each output word field by field. A directed opening covers
// code extremes, silence and data frames, shortened and lengthened frames and
// a disabled block. Random phases follow, one per frame length and idling
// mix, with register writes only once the block has drained.
// ---------------------------------------------------------------------------
module tb_top;
  import dafeed_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic             kind;
    logic [PCM_W-1:0] pcm;
  } feed_item_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              silence;
    logic              start;
  } dac_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_PUSH;
  logic [PCM_W-1:0]      in_pcm_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CODE_W-1:0]     out_dac_word;
  logic                  out_is_silence;
  logic                  out_frame_start;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feed_item_t sample_feed_q[$];
  dac_out_t   pending_words[$];

  // model of the feeder state
  logic [CODE_W-1:0] code_mem [STORE_DEPTH_DEF];
  int unsigned       wr_ptr, rd_ptr, fill_cnt, frame_pos;
  bit                in_silence, feed_en;
  logic [FL_W-1:0]   flen;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_taken = 1'b0;
  int  n_queued = 0, n_taken = 0, quiet = 0, fails = 0;
  int  n_pushed = 0, n_dropped = 0, n_data = 0, n_silence = 0, n_dry = 0;
  int  n_checked = 0, n_frames = 0, n_cfg = 0;

  dac_audio_frame_feeder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_pcm_sample   (in_pcm_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dac_word    (out_dac_word),
    .out_is_silence  (out_is_silence),
    .out_frame_start (out_frame_start),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic feed_word(input logic kind, input logic [PCM_W-1:0] pcm);
    int unsigned len, cap;
    logic [PCM_W-1:0] flipped;
    dac_out_t w;
    if (!feed_en) return;
    len = (flen == 0) ? 1 : ((flen > MAX_FRAME_DEF) ? MAX_FRAME_DEF : flen);
    cap = FIFO_FRAMES * len;
    if (cap > STORE_DEPTH_DEF) cap = STORE_DEPTH_DEF;
    if (kind == KIND_PUSH) begin
      if (fill_cnt >= cap) begin
        n_dropped++;
        return;
      end
      flipped = pcm ^ 16'h8000;
      code_mem[wr_ptr] = flipped[PCM_W-1 -: CODE_W];
      wr_ptr = (wr_ptr + 1) % STORE_DEPTH_DEF;
      fill_cnt++;
      n_pushed++;
      return;
    end
    w.code = '0;
    w.start = 1'b0;
    if (frame_pos == 0) begin
      w.start = 1'b1;
      in_silence = (fill_cnt < len);
      n_frames++;
    end
    if (!in_silence && fill_cnt > 0) begin
      w.code = code_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % STORE_DEPTH_DEF;
      fill_cnt--;
      n_data++;
    end else if (!in_silence) begin
      n_dry++;
    end else begin
      n_silence++;
    end
    frame_pos++;
    if (frame_pos >= len) frame_pos = 0;
    w.silence = in_silence;
    pending_words.push_back(w);
  endtask

  // driver
  always @(negedge clk) begin
    feed_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = sample_feed_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= nxt.kind;
        in_pcm_sample <= nxt.pcm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and predictor
  always @(posedge clk) begin
    dac_out_t e;
    bit fired;
    in_taken <= in_valid && in_ready;
    if (!rst_n) begin
      wr_ptr = 0;
      rd_ptr = 0;
      fill_cnt = 0;
      frame_pos = 0;
      in_silence = 1'b0;
      feed_en = 1'b0;
      flen = FL_W'(RESET_FRAME_LEN);
      pending_words.delete();
    end else begin
      fired = 1'b0;
      if (out_valid && out_ready) begin
        fired = 1'b1;
        if (pending_words.size() == 0) begin
          $error("unexpected word: dac_word %0h is_silence %0b frame_start %0b",
                 out_dac_word, out_is_silence, out_frame_start);
          fails++;
        end else begin
          e = pending_words.pop_front();
          n_checked++;
          if (out_dac_word !== e.code) begin
            $error("dac_word: expected %0h, got %0h", e.code, out_dac_word);
            fails++;
          end
          if (out_is_silence !== e.silence) begin
            $error("is_silence: expected %0b, got %0b", e.silence, out_is_silence);
            fails++;
          end
          if (out_frame_start !== e.start) begin
            $error("frame_start: expected %0b, got %0b", e.start, out_frame_start);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        fired = 1'b1;
        n_cfg++;
        case (cfg_index)
          REG_ENABLE: begin
            feed_en = cfg_data[0];
          end
          REG_FRAME_LEN: begin
            flen = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        fired = 1'b1;
        n_taken++;
        feed_word(in_kind, in_pcm_sample);
      end
      quiet = fired ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("dac_audio_frame_feeder verification failed");
        $finish;
      end
    end
  end

  task automatic add_item(input logic kind, input logic [PCM_W-1:0] pcm);
    feed_item_t it;
    it.kind = kind;
    it.pcm = pcm;
    sample_feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic random_items(input int n, input int push_pct);
    logic [PCM_W-1:0] pcm;
    for (int i = 0; i < n; i++) begin
      pcm = PCM_W'($urandom);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: pcm = 16'h8000;
          1: pcm = 16'h7FFF;
          2: pcm = 16'h0000;
          default: pcm = 16'hFFFF;
        endcase
      end
      add_item(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_TICK, pcm);
    end
  endtask

  // wait until every word is taken and every result is back
  task automatic drain();
    do @(negedge clk);
    while (n_taken != n_queued || pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 74;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 74;
      end
      default: begin
        send_idle_pct = 36;
        recv_stall_pct = 36;
      end
    endcase
  endtask

  initial begin
    logic [FL_W-1:0] plen [9];
    int              ppct [9];
    int              pnum [9];
    plen = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd120, 8'd60,
             FL_W'($urandom_range(16, 2)), FL_W'($urandom_range(16, 2)),
             FL_W'($urandom_range(100, 17))};
    ppct = '{70, 40, 85, 40, 55, 50, 60, 40, 55};
    pnum = '{120, 120, 200, 220, 200, 150, 150, 150, 150};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled block ignores everything
    add_item(KIND_PUSH, 16'h1234);
    add_item(KIND_TICK, 16'h0000);
    add_item(KIND_PUSH, 16'h8000);
    drain();

    write_reg(REG_ENABLE, 8'h01);
    write_reg(REG_FRAME_LEN, 8'd4);
    // silence frame, then code extremes, then a data frame left at position 3
    add_item(KIND_TICK, 16'h0000);
    add_item(KIND_TICK, 16'hFFFF);
    add_item(KIND_PUSH, 16'h8000);
    add_item(KIND_PUSH, 16'h7FFF);
    add_item(KIND_PUSH, 16'h0000);
    add_item(KIND_PUSH, 16'hFFFF);
    add_item(KIND_PUSH, 16'h0010);
    add_item(KIND_PUSH, 16'h000F);
    add_item(KIND_PUSH, 16'h5A5A);
    repeat (5) add_item(KIND_TICK, 16'h0000);
    drain();

    // shortened frame ends after the current word
    write_reg(REG_FRAME_LEN, 8'd2);
    repeat (2) add_item(KIND_TICK, 16'h0000);
    drain();

    // lengthened frame runs dry
    write_reg(REG_FRAME_LEN, 8'd8);
    repeat (3) add_item(KIND_TICK, 16'h0000);
    drain();

    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));

    for (int p = 0; p < 9; p++) begin
      write_reg(REG_FRAME_LEN, plen[p]);
      set_idling(p);
      random_items(pnum[p], ppct[p]);
      drain();
      if (p == 4) begin
        // enable toggle keeps fifo and frame state
        write_reg(REG_ENABLE, 8'hA6);
        set_idling(3);
        random_items(20, 50);
        drain();
        write_reg(REG_ENABLE, 8'hFF);
      end
    end

    set_idling(0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      fails++;
    end
    $display("covered %0d input words, %0d register writes, %0d frames",
             n_taken, n_cfg, n_frames);
    $display("checked %0d dac words: %0d data, %0d silence, %0d dry; %0d pushes, %0d dropped",
             n_checked, n_data, n_silence, n_dry, n_pushed, n_dropped);
    if (fails == 0) begin
      $display("dac_audio_frame_feeder verification clean");
    end else begin
      $display("dac_audio_frame_feeder verification failed");
    end
    $finish;
  end

endmodule
